FILE: rtl/core/modexp_pkg.sv
// modexp_pkg: widths, reset constants and request/response types for the
// modular exponentiation block; no dependencies, compiled first
`default_nettype none

package modexp_pkg;

	localparam int unsigned MOD_W     = 31;
	localparam int unsigned BASE_W    = 32;
	localparam int unsigned EXP_W     = 63;
	localparam int unsigned EXP_EXT_W = 64;
	localparam int unsigned CNT_W     = $clog2(BASE_W);

	localparam logic [MOD_W-1:0] MOD_RESET = 31'd998244353;
	localparam logic [MOD_W-1:0] MOD_ONE   = 31'd1;
	localparam logic [MOD_W-1:0] MOD_TWO   = 31'd2;

	typedef struct packed {
		logic              start;
		logic [MOD_W-1:0]  x;
		logic [BASE_W-1:0] y;
	} mm_req_t;

	typedef struct packed {
		logic             done;
		logic [MOD_W-1:0] prod;
	} mm_rsp_t;

endpackage

`default_nettype wire

FILE: rtl/core/modexp_if.sv
// modexp_in_if / modexp_out_if: valid/ready channels for operand and result beats
// depends on modexp_pkg for field widths
`default_nettype none

interface modexp_in_if;
	logic                          valid;
	logic                          ready;
	logic [modexp_pkg::BASE_W-1:0] base;
	logic [modexp_pkg::EXP_W-1:0]  exponent;

	modport source (output valid, output base, output exponent, input ready);
	modport sink (input valid, input base, input exponent, output ready);
endinterface

interface modexp_out_if;
	logic                         valid;
	logic                         ready;
	logic [modexp_pkg::MOD_W-1:0] residue;

	modport source (output valid, output residue, input ready);
	modport sink (input valid, input residue, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/modular_exponentiation.sv
// modular_exponentiation: base ** exponent mod modulus, right-to-left square
// and multiply around one shared modexp_mulmod; depends on modexp_pkg, modexp_if
// each modular product runs over the 32 multiplier bits in modexp_mulmod
// products: 1 reduction + popcount(exponent) + msb index, none with modulus below two
// next beat taken while a result waits; async reset, modulus to 998244353, ready at once
`default_nettype none

module modular_exponentiation #(
	parameter int unsigned EXPONENT_BITS = 63
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [modexp_pkg::MOD_W-1:0] cfg_wdata,
	modexp_in_if.sink                         item,
	modexp_out_if.source                      result
);
	import modexp_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_REDUCE = 6'b000010,
		ST_STEP   = 6'b000100,
		ST_MUL    = 6'b001000,
		ST_SQR    = 6'b010000,
		ST_DONE   = 6'b100000
	} state_t;

	state_t                   state_q;
	state_t                   state_d;
	logic [MOD_W-1:0]         modulus_q;
	logic                     ovalid_q;
	logic [MOD_W-1:0]         res_q;
	logic [MOD_W-1:0]         acc_q;
	logic [MOD_W-1:0]         b_q;
	logic [EXPONENT_BITS-1:0] e_q;
	logic [EXP_EXT_W-1:0]     exp_ext;
	logic                     accept;
	logic                     out_free;
	mm_req_t                  mm_req;
	mm_rsp_t                  mm_rsp;

	modexp_mulmod u_mulmod (
		.clk     (clk),
		.arst_n  (arst_n),
		.modulus (modulus_q),
		.req     (mm_req),
		.rsp     (mm_rsp)
	);

	assign item.ready     = (state_q == ST_IDLE);
	assign accept         = item.valid && item.ready;
	assign out_free       = !ovalid_q || result.ready;
	assign exp_ext        = {1'b0, item.exponent};
	assign result.valid   = ovalid_q;
	assign result.residue = res_q;

	always_comb begin
		state_d = state_q;
		mm_req  = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (modulus_q < MOD_TWO) begin
						state_d = ST_DONE;
					end else begin
						mm_req.start = 1'b1;
						mm_req.x     = MOD_ONE;
						mm_req.y     = item.base;
						state_d      = ST_REDUCE;
					end
				end
			end
			ST_REDUCE: begin
				if (mm_rsp.done) begin
					state_d = ST_STEP;
				end
			end
			ST_STEP: begin
				if (e_q == '0) begin
					state_d = ST_DONE;
				end else if (e_q[0]) begin
					mm_req.start = 1'b1;
					mm_req.x     = acc_q;
					mm_req.y     = {1'b0, b_q};
					state_d      = ST_MUL;
				end else begin
					mm_req.start = 1'b1;
					mm_req.x     = b_q;
					mm_req.y     = {1'b0, b_q};
					state_d      = ST_SQR;
				end
			end
			ST_MUL: begin
				if (mm_rsp.done) begin
					state_d = ST_STEP;
				end
			end
			ST_SQR: begin
				if (mm_rsp.done) begin
					state_d = ST_STEP;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			ovalid_q  <= 1'b0;
			modulus_q <= MOD_RESET;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				modulus_q <= cfg_wdata;
			end
			if (state_q == ST_DONE && out_free) begin
				ovalid_q <= 1'b1;
			end else if (result.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					e_q   <= exp_ext[EXPONENT_BITS-1:0];
					acc_q <= '0;
				end
			end
			ST_REDUCE: begin
				if (mm_rsp.done) begin
					b_q   <= mm_rsp.prod;
					acc_q <= MOD_ONE;
				end
			end
			ST_MUL: begin
				if (mm_rsp.done) begin
					acc_q  <= mm_rsp.prod;
					e_q[0] <= 1'b0;
				end
			end
			ST_SQR: begin
				if (mm_rsp.done) begin
					b_q <= mm_rsp.prod;
					e_q <= e_q >> 1;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					res_q <= acc_q;
				end
			end
			default: begin
			end
		endcase
	end

	a_start_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		mm_req.start |-> (state_q == ST_IDLE || state_q == ST_STEP))
		else $error("product started outside the sequencer steps");

	a_no_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE || state_q == ST_DONE || state_q == ST_STEP) |-> !mm_rsp.done)
		else $error("product finished with no one waiting");

	a_result_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(ovalid_q && modulus_q >= MOD_TWO) |-> (res_q < modulus_q))
		else $error("result not reduced");

	a_step_after_product: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL && mm_rsp.done) |=> (state_q == ST_STEP && !e_q[0]))
		else $error("multiply did not retire its exponent bit");

endmodule

`default_nettype wire

FILE: rtl/core/modexp_mulmod.sv
// modexp_mulmod: bit-serial interleaved modular multiplier, (x * y) mod m,
// one multiplier bit per cycle, msb first; depends on modexp_pkg
`default_nettype none

module modexp_mulmod (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [modexp_pkg::MOD_W-1:0]  modulus,
	input  wire modexp_pkg::mm_req_t           req,
	output modexp_pkg::mm_rsp_t                rsp
);
	import modexp_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [MOD_W-1:0]  acc_q;
	logic [MOD_W-1:0]  x_q;
	logic [BASE_W-1:0] y_q;

	logic [MOD_W+1:0]  t;
	logic [MOD_W+1:0]  m1_ext;
	logic [MOD_W+1:0]  m2_ext;
	logic [MOD_W+1:0]  diff1;
	logic [MOD_W+1:0]  diff2;
	logic [MOD_W-1:0]  acc_nxt;

	// partial sum stays below 3m, so at most two subtractions
	always_comb begin
		m1_ext  = {2'b00, modulus};
		m2_ext  = {1'b0, modulus, 1'b0};
		t       = {1'b0, acc_q, 1'b0} + (y_q[BASE_W-1] ? {2'b00, x_q} : '0);
		diff1   = t - m1_ext;
		diff2   = t - m2_ext;
		if (t >= m2_ext) begin
			acc_nxt = diff2[MOD_W-1:0];
		end else if (t >= m1_ext) begin
			acc_nxt = diff1[MOD_W-1:0];
		end else begin
			acc_nxt = t[MOD_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(BASE_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= '0;
			x_q   <= req.x;
			y_q   <= req.y;
		end else if (busy_q) begin
			acc_q <= acc_nxt;
			y_q   <= {y_q[BASE_W-2:0], 1'b0};
		end
	end

	assign rsp.done = done_q;
	assign rsp.prod = acc_q;

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("mulmod done without a running product");

	a_prod_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && modulus >= MOD_TWO) |-> (acc_q < modulus))
		else $error("mulmod result not reduced");

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !req.start)
		else $error("mulmod started while busy");

endmodule

`default_nettype wire
